// ===== rtl/pf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and helper functions of the playfair digraph cipher.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int SIDE      = 5;
  localparam int CELLS     = SIDE * SIDE;
  localparam int LETTER_W  = 5;
  localparam int SQUARE_W  = CELLS * LETTER_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 45;
  localparam int FIRST_W   = 45;
  localparam int MIDDLE_W  = 40;
  localparam int LAST_W    = 40;

  localparam logic [LETTER_W-1:0] LETTER_I      = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J      = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_Z      = 5'd25;
  localparam logic [LETTER_W-1:0] FILLER_RESET  = 5'd6;
  localparam logic [7:0]          LOWER_A       = 8'd97;
  localparam logic [7:0]          LOWER_Z       = 8'd122;
  localparam logic [7:0]          UPPER_A       = 8'd65;
  localparam logic [7:0]          UPPER_Z       = 8'd90;
  localparam logic [6:0]          ASCII_A       = 7'd97;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SQUARE_FIRST  = 3'd0,
    CFG_SQUARE_MIDDLE = 3'd1,
    CFG_SQUARE_LAST   = 3'd2,
    CFG_FILLER_LETTER = 3'd3,
    CFG_DECRYPT_MODE  = 3'd4
  } cfg_index_t;

  typedef logic [SQUARE_W-1:0] square_t;
  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [2:0]          coord_t;

  typedef struct packed {
    square_t square;
    letter_t filler;
    logic    decrypt;
  } cfg_t;

  // one or two letter pairs, held as cell positions in the square
  typedef struct packed {
    logic    two;
    letter_t p0a;
    letter_t p0b;
    letter_t p1a;
    letter_t p1b;
    logic    last;
  } job_t;

  function automatic letter_t fold_letter(input letter_t v);
    fold_letter = (v == LETTER_J) ? LETTER_I : v;
  endfunction

  // first cell holding the letter, cell 0 when absent
  function automatic letter_t locate(input square_t sq, input letter_t letter);
    letter_t pos;
    pos = '0;
    for (int k = CELLS - 1; k >= 0; k--) begin
      if (sq[LETTER_W*k +: LETTER_W] == letter) pos = LETTER_W'(k);
    end
    locate = pos;
  endfunction

  function automatic coord_t pos_row(input letter_t p);
    coord_t r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    pos_row = r;
  endfunction

  function automatic letter_t row_base(input coord_t r);
    row_base = {r, 2'b00} + {2'b00, r};
  endfunction

  function automatic coord_t pos_col(input letter_t p);
    letter_t d;
    d = p - row_base(pos_row(p));
    pos_col = d[2:0];
  endfunction

  function automatic coord_t wrap_step(input coord_t v, input logic back);
    coord_t r;
    if (back) r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
    else r = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    wrap_step = r;
  endfunction

  function automatic logic [6:0] to_ascii(input letter_t v);
    letter_t c;
    c = (v > LETTER_Z) ? LETTER_Z : v;
    to_ascii = ASCII_A + {2'b00, c};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/playfair_digraph_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher over a byte stream: letters are paired, substituted through
// the configured 5x5 key square and sent out one letter per word.
// The first letter of a pair passes through the pair queue and then the output
// register once the byte that completes the pair is accepted.
// Throughput: one output letter per cycle while out_stall is low; a pair gives
// two output letters and a doubled pair plus end flush gives four. A two-entry
// pair queue lets bytes enter every cycle while the output side keeps up.
// Reset: empties the queue and output, clears the pending letter, zeroes the
// square, filler 'g', encrypt mode.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_char,
  input  wire logic                           in_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [6:0]                          out_char,
  output logic                                out_last,
  output logic                                message_end
);
  import pf_pkg::*;

  logic [FIRST_W-1:0]  square_first;
  logic [MIDDLE_W-1:0] square_middle;
  logic [LAST_W-1:0]   square_last;
  letter_t             filler_letter;
  logic                decrypt_mode;
  cfg_t                cfg;

  logic  in_accept, fr_job_valid, push, pop, load_out, final_pos;
  job_t  fr_job, head;
  job_t  jobs [2];
  logic  wr_ptr, rd_ptr;
  logic [1:0] count;
  logic [1:0] pos;
  letter_t pa, pb;
  logic [6:0] char_a, char_b;

  assign cfg_ready = 1'b1;
  assign cfg = '{square: {square_last, square_middle, square_first},
                 filler: filler_letter, decrypt: decrypt_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      square_first  <= '0;
      square_middle <= '0;
      square_last   <= '0;
      filler_letter <= FILLER_RESET;
      decrypt_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SQUARE_FIRST:  square_first  <= cfg_data[FIRST_W-1:0];
        CFG_SQUARE_MIDDLE: square_middle <= cfg_data[MIDDLE_W-1:0];
        CFG_SQUARE_LAST:   square_last   <= cfg_data[LAST_W-1:0];
        CFG_FILLER_LETTER: filler_letter <= cfg_data[LETTER_W-1:0];
        CFG_DECRYPT_MODE:  decrypt_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .in_char   (in_char),
    .in_last   (in_last),
    .cfg       (cfg),
    .job_valid (fr_job_valid),
    .job       (fr_job)
  );

  // pair queue
  assign head      = jobs[rd_ptr];
  assign final_pos = head.two ? (pos == 2'd3) : (pos == 2'd1);
  assign load_out  = !out_valid || !out_stall;
  assign pop       = (count != 2'd0) && load_out && final_pos;
  assign in_stall  = (count == 2'd2) && !pop;
  assign in_accept = in_valid && !in_stall;
  assign push      = in_accept && fr_job_valid;

  always_ff @(posedge clk) begin
    if (push) jobs[wr_ptr] <= fr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign pa = pos[1] ? head.p1a : head.p0a;
  assign pb = pos[1] ? head.p1b : head.p0b;

  pf_subst u_subst (
    .pos_a  (pa),
    .pos_b  (pb),
    .cfg    (cfg),
    .char_a (char_a),
    .char_b (char_b)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load_out) begin
      out_valid <= (count != 2'd0);
      if (count != 2'd0) pos <= final_pos ? 2'd0 : pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && count != 2'd0) begin
      out_char    <= pos[0] ? char_b : char_a;
      out_last    <= final_pos;
      message_end <= final_pos && head.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("pair queue overflow");
  assert property (@(posedge clk) disable iff (rst) pos != 2'd0 |-> count != 2'd0)
    else $error("letter position advanced with empty queue");
  assert property (@(posedge clk) disable iff (rst) in_stall |-> count == 2'd2)
    else $error("stall while queue has room");
  assert property (@(posedge clk) disable iff (rst) out_valid && message_end |-> out_last)
    else $error("message end on a letter that is not last of its word group");

endmodule
`default_nettype wire

// ===== rtl/pf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pf_front
// Letter filter and pairing; holds the pending letter and locates each pair
// letter in the key square.
// ----------------------------------------------------------------------------
module pf_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   in_char,
  input  wire logic         in_last,
  input  wire pf_pkg::cfg_t cfg,
  output logic              job_valid,
  output pf_pkg::job_t      job
);
  import pf_pkg::*;

  logic    pending_valid, pending_valid_next;
  letter_t pending_letter, pending_letter_next;

  letter_t fill, letter;
  logic    is_letter;
  logic [7:0] offs;
  letter_t pos_pend, pos_let, pos_fill, pos_mid;
  logic    pair0, pv_mid, flush;
  letter_t pl_mid;

  always_comb begin
    fill = fold_letter(cfg.filler);
    is_letter = 1'b0;
    offs = '0;
    if (in_char >= LOWER_A && in_char <= LOWER_Z) begin
      is_letter = 1'b1;
      offs = in_char - LOWER_A;
    end else if (in_char >= UPPER_A && in_char <= UPPER_Z) begin
      is_letter = 1'b1;
      offs = in_char - UPPER_A;
    end
    letter = fold_letter(offs[LETTER_W-1:0]);

    pos_pend = locate(cfg.square, pending_letter);
    pos_let  = locate(cfg.square, letter);
    pos_fill = locate(cfg.square, fill);

    job = '0;
    pair0 = 1'b0;
    pv_mid = pending_valid;
    pl_mid = pending_letter;
    pos_mid = pos_pend;

    if (is_letter) begin
      if (!pending_valid) begin
        pv_mid = 1'b1;
        pl_mid = letter;
        pos_mid = pos_let;
      end else if (letter == pending_letter && !cfg.decrypt) begin
        // doubled letter: pair with filler, second letter stays pending
        pair0 = 1'b1;
        job.p0a = pos_pend;
        job.p0b = pos_fill;
        pl_mid = letter;
        pos_mid = pos_let;
      end else begin
        pair0 = 1'b1;
        job.p0a = pos_pend;
        job.p0b = pos_let;
        pv_mid = 1'b0;
        pl_mid = '0;
      end
    end

    // lone letter at end of message
    flush = in_last && pv_mid;
    if (flush) begin
      if (pair0) begin
        job.two = 1'b1;
        job.p1a = pos_mid;
        job.p1b = pos_fill;
      end else begin
        job.p0a = pos_mid;
        job.p0b = pos_fill;
      end
    end
    job.last = in_last;
    job_valid = pair0 || flush;

    pending_valid_next  = flush ? 1'b0 : pv_mid;
    pending_letter_next = flush ? '0 : pl_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      pending_letter <= '0;
    end else if (accept) begin
      pending_valid  <= pending_valid_next;
      pending_letter <= pending_letter_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pf_subst.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pf_subst
// Digraph substitution of one located pair through the key square.
// ----------------------------------------------------------------------------
module pf_subst (
  input  wire pf_pkg::letter_t pos_a,
  input  wire pf_pkg::letter_t pos_b,
  input  wire pf_pkg::cfg_t    cfg,
  output logic [6:0]           char_a,
  output logic [6:0]           char_b
);
  import pf_pkg::*;

  letter_t cells [CELLS];
  coord_t  r1, c1, r2, c2;
  coord_t  or1, oc1, or2, oc2;
  letter_t o1, o2;

  for (genvar k = 0; k < CELLS; k++) begin : g_cells
    assign cells[k] = cfg.square[LETTER_W*k +: LETTER_W];
  end

  always_comb begin
    r1 = pos_row(pos_a);
    c1 = pos_col(pos_a);
    r2 = pos_row(pos_b);
    c2 = pos_col(pos_b);
    if (r1 == r2) begin
      or1 = r1;
      or2 = r2;
      oc1 = wrap_step(c1, cfg.decrypt);
      oc2 = wrap_step(c2, cfg.decrypt);
    end else if (c1 == c2) begin
      or1 = wrap_step(r1, cfg.decrypt);
      or2 = wrap_step(r2, cfg.decrypt);
      oc1 = c1;
      oc2 = c2;
    end else begin
      or1 = r1;
      or2 = r2;
      oc1 = c2;
      oc2 = c1;
    end
    o1 = row_base(or1) + {2'b00, oc1};
    o2 = row_base(or2) + {2'b00, oc2};
    char_a = to_ascii(cells[o1]);
    char_b = to_ascii(cells[o2]);
  end

endmodule
`default_nettype wire
